[rtl/tbt_pkg.sv]
package tbt_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int CMD_Q_DEPTH  = 4;
  localparam int RES_Q_DEPTH  = 2;

  localparam int VAL_W   = 24;
  localparam int SMP_W   = 16;
  localparam int CH_W    = 4;
  localparam int THR_W   = 25;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // shared multiply/divide unit: multiplier operand and dividend widths
  localparam int MD_A_W = 25;
  localparam int MD_N_W = 50;

  localparam logic [1:0] MODE_CAL   = 2'd0;
  localparam logic [1:0] MODE_TRACK = 2'd1;

  localparam logic [2:0] REG_CIU  = 3'd0;
  localparam logic [2:0] REG_SP   = 3'd1;
  localparam logic [2:0] REG_WP   = 3'd2;
  localparam logic [2:0] REG_FP   = 3'd3;
  localparam logic [2:0] REG_TF   = 3'd4;
  localparam logic [2:0] REG_TOFF = 3'd5;
  localparam logic [2:0] REG_CS   = 3'd6;

  localparam logic [4:0]  CIU_RST  = 5'd10;
  localparam logic [9:0]  SP_RST   = 10'd10;
  localparam logic [15:0] WP_RST   = 16'd2000;
  localparam logic [15:0] FP_RST   = 16'd10000;
  localparam logic [15:0] TF_RST   = 16'd768;
  localparam logic [23:0] TOFF_RST = 24'd2560;
  localparam logic [7:0]  CS_RST   = 8'd20;

  typedef enum logic [2:0] {
    OP_QUERY,
    OP_CAL,
    OP_STEADY,
    OP_WARM,
    OP_ERR
  } op_t;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    logic [4:0]  ciu;
    logic [9:0]  sp;
    logic [15:0] wp;
    logic [15:0] fp;
    logic [15:0] tf;
    logic [23:0] toff;
    logic [7:0]  cs;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] smp;
  } cmd_t;

  typedef struct packed {
    logic             touched;
    logic [THR_W-1:0] thr;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] dev;
    logic             status;
  } res_t;

  typedef struct packed {
    logic              start;
    md_op_t            op;
    logic [MD_N_W-1:0] a;
    logic [MD_A_W-1:0] b;
  } md_req_t;

endpackage

[rtl/touch_baseline_tracker.sv]
// Per-channel capacitive touch baseline tracker.
// Input side is a queue: drive in_* and push; the transaction is taken at
// a clock edge with push high and full low. Result side is a queue too:
// while empty is low the oldest result sits on out_*, and pop with empty
// low takes it. Every input transaction yields exactly one result, in order.
// Config registers sit on an APB-style port (4-byte stride, pready tied
// high); write them only while no transaction is in flight.
// The back end handles one transaction at a time around a shared
// shift-add multiplier / restoring divider. A query, a steady tracking or
// mid-calibration sample needs one multiply; warm-up tracking adds two
// multiply/divide pairs; the closing sample of a calibration run adds a
// divide and two multiply/divide pairs; a bad channel needs neither. A 4-entry
// command queue and 2-entry result queue decouple the ports from the back end.
// Reset (rst_n low, synchronous) restores default registers and empties
// both queues; per-channel state reads as zero until first written.
// A stalled receiver fills the result queue, the back end holds its
// finished result, then the command queue fills and full rises.
module touch_baseline_tracker #(
  parameter int CHANNELS = tbt_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tbt_pkg::PADDR_W-1:0]       paddr,
  input  logic [tbt_pkg::PDATA_W-1:0]       pwdata,
  output logic [tbt_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        in_mode,
  input  logic [tbt_pkg::CH_W-1:0]          in_channel,
  input  logic [tbt_pkg::SMP_W-1:0]         in_sample,
  input  logic [31:0]                       in_elapsed_ms,
  output logic                              empty,
  input  logic                              pop,
  output logic                              out_touched,
  output logic signed [tbt_pkg::THR_W-1:0]  out_threshold,
  output logic [tbt_pkg::VAL_W-1:0]         out_baseline_out,
  output logic [tbt_pkg::VAL_W-1:0]         out_deviation_out,
  output logic                              out_status
);

  localparam int CMD_W = $bits(tbt_pkg::cmd_t);
  localparam int RES_W = $bits(tbt_pkg::res_t);

  tbt_pkg::cfg_t    cfg;
  tbt_pkg::cmd_t    cmd_in;
  tbt_pkg::cmd_t    cq_dout;
  tbt_pkg::res_t    rq_din;
  tbt_pkg::res_t    rq_dout;
  tbt_pkg::md_req_t md_req;
  logic [CMD_W-1:0] cq_dout_bits;
  logic [RES_W-1:0] rq_dout_bits;
  logic             cq_empty;
  logic             cq_pop;
  logic             rq_full;
  logic             rq_push;
  logic             md_done;
  logic [tbt_pkg::MD_N_W-1:0] md_res;

  // front end: config registers plus channel / warm-up classification
  tbt_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_mode, .in_channel, .in_sample, .in_elapsed_ms,
    .cmd(cmd_in), .cfg(cfg)
  );

  // classified commands wait here until the back end is free
  tbt_fifo #(.DEPTH(tbt_pkg::CMD_Q_DEPTH), .WIDTH(CMD_W)) u_cmd_q (
    .clk, .rst_n, .push(push), .din(cmd_in), .full(full),
    .pop(cq_pop), .dout(cq_dout_bits), .empty(cq_empty)
  );

  assign cq_dout = tbt_pkg::cmd_t'(cq_dout_bits);

  tbt_back #(.CHANNELS(CHANNELS)) u_back (
    .clk, .rst_n, .cfg, .cq_dout, .cq_empty, .cq_pop,
    .rq_full, .rq_push, .rq_din, .md_req, .md_done, .md_res
  );

  tbt_muldiv u_muldiv (
    .clk, .rst_n, .req(md_req), .done(md_done), .res(md_res)
  );

  // finished results; lets the back end move on while the receiver stalls
  tbt_fifo #(.DEPTH(tbt_pkg::RES_Q_DEPTH), .WIDTH(RES_W)) u_res_q (
    .clk, .rst_n, .push(rq_push), .din(rq_din), .full(rq_full),
    .pop(pop), .dout(rq_dout_bits), .empty(empty)
  );

  assign rq_dout           = tbt_pkg::res_t'(rq_dout_bits);
  assign out_touched       = rq_dout.touched;
  assign out_threshold     = rq_dout.thr;
  assign out_baseline_out  = rq_dout.base;
  assign out_deviation_out = rq_dout.dev;
  assign out_status        = rq_dout.status;

endmodule

[rtl/tbt_fifo.sv]
module tbt_fifo #(
  parameter int DEPTH = tbt_pkg::CMD_Q_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r;
  logic [AW-1:0]    rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/tbt_front.sv]
module tbt_front #(
  parameter int CHANNELS = tbt_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbt_pkg::PADDR_W-1:0]  paddr,
  input  logic [tbt_pkg::PDATA_W-1:0]  pwdata,
  output logic [tbt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic [1:0]                   in_mode,
  input  logic [tbt_pkg::CH_W-1:0]     in_channel,
  input  logic [tbt_pkg::SMP_W-1:0]    in_sample,
  input  logic [31:0]                  in_elapsed_ms,
  output tbt_pkg::cmd_t                cmd,
  output tbt_pkg::cfg_t                cfg
);

  tbt_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          in_use;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tbt_pkg::PADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ciu: tbt_pkg::CIU_RST, sp: tbt_pkg::SP_RST, wp: tbt_pkg::WP_RST,
                 fp: tbt_pkg::FP_RST, tf: tbt_pkg::TF_RST, toff: tbt_pkg::TOFF_RST,
                 cs: tbt_pkg::CS_RST};
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        tbt_pkg::REG_CIU:  cfg_r.ciu  <= pwdata[4:0];
        tbt_pkg::REG_SP:   cfg_r.sp   <= pwdata[9:0];
        tbt_pkg::REG_WP:   cfg_r.wp   <= pwdata[15:0];
        tbt_pkg::REG_FP:   cfg_r.fp   <= pwdata[15:0];
        tbt_pkg::REG_TF:   cfg_r.tf   <= pwdata[15:0];
        tbt_pkg::REG_TOFF: cfg_r.toff <= pwdata[23:0];
        tbt_pkg::REG_CS:   cfg_r.cs   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tbt_pkg::REG_CIU:  prdata = {27'b0, cfg_r.ciu};
      tbt_pkg::REG_SP:   prdata = {22'b0, cfg_r.sp};
      tbt_pkg::REG_WP:   prdata = {16'b0, cfg_r.wp};
      tbt_pkg::REG_FP:   prdata = {16'b0, cfg_r.fp};
      tbt_pkg::REG_TF:   prdata = {16'b0, cfg_r.tf};
      tbt_pkg::REG_TOFF: prdata = {8'b0, cfg_r.toff};
      tbt_pkg::REG_CS:   prdata = {24'b0, cfg_r.cs};
      default:           prdata = '0;
    endcase
  end

  // classify: channel check and warm-up decision happen here
  assign in_use = ({1'b0, in_channel} < cfg_r.ciu) && (int'(in_channel) < CHANNELS);

  always_comb begin
    cmd.ch  = in_channel;
    cmd.smp = in_sample;
    unique case (in_mode)
      tbt_pkg::MODE_CAL:   cmd.op = tbt_pkg::OP_CAL;
      tbt_pkg::MODE_TRACK: cmd.op = (in_elapsed_ms < {16'b0, cfg_r.wp}) ?
                                    tbt_pkg::OP_WARM : tbt_pkg::OP_STEADY;
      default:             cmd.op = tbt_pkg::OP_QUERY;
    endcase
    if (!in_use) begin
      cmd.op = tbt_pkg::OP_ERR;
    end
  end

endmodule

[rtl/tbt_muldiv.sv]
module tbt_muldiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbt_pkg::md_req_t            req,
  output logic                        done,
  output logic [tbt_pkg::MD_N_W-1:0]  res
);

  localparam int AW   = tbt_pkg::MD_A_W;
  localparam int NW   = tbt_pkg::MD_N_W;
  localparam int CNTW = $clog2(NW);

  tbt_pkg::md_op_t op_r;
  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   acc_r;
  logic [NW-1:0]   mcand_r;
  logic [AW-1:0]   mpl_r;
  logic [AW-1:0]   rem_r;
  logic [AW-1:0]   dvs_r;
  logic [AW:0]     rem_sh;
  logic            ge;
  logic [CNTW-1:0] last;

  assign rem_sh = {rem_r, acc_r[NW-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});
  assign last   = (op_r == tbt_pkg::MD_MUL) ? CNTW'(AW - 1) : CNTW'(NW - 1);
  assign done   = done_r;
  assign res    = acc_r;

  // shift-add multiply, one multiplier bit a cycle; restoring divide, one
  // quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        if (req.op == tbt_pkg::MD_MUL) begin
          acc_r   <= '0;
          mcand_r <= {{(NW-AW){1'b0}}, req.b};
          mpl_r   <= req.a[AW-1:0];
        end else begin
          acc_r <= req.a;
          rem_r <= '0;
          dvs_r <= req.b;
        end
      end else if (busy_r) begin
        if (op_r == tbt_pkg::MD_MUL) begin
          acc_r   <= acc_r + (mpl_r[0] ? mcand_r : '0);
          mcand_r <= mcand_r << 1;
          mpl_r   <= mpl_r >> 1;
        end else begin
          rem_r <= ge ? AW'(rem_sh - {1'b0, dvs_r}) : rem_sh[AW-1:0];
          acc_r <= {acc_r[NW-2:0], ge};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/tbt_back.sv]
module tbt_back #(
  parameter int CHANNELS = tbt_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbt_pkg::cfg_t               cfg,
  input  tbt_pkg::cmd_t               cq_dout,
  input  logic                        cq_empty,
  output logic                        cq_pop,
  input  logic                        rq_full,
  output logic                        rq_push,
  output tbt_pkg::res_t               rq_din,
  output tbt_pkg::md_req_t            md_req,
  input  logic                        md_done,
  input  logic [tbt_pkg::MD_N_W-1:0]  md_res
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = tbt_pkg::MD_N_W;

  typedef struct packed {
    logic [23:0] b;
    logic [23:0] dv;
    logic [23:0] bs;
    logic [23:0] ds;
    logic [7:0]  cc;
    logic [15:0] fs;
    logic [23:0] ads;
  } chan_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_THR, ST_CAL_DIV, ST_BS_MUL, ST_BS_DIV, ST_DS_MUL,
    ST_DS_DIV, ST_WB_MUL, ST_WB_DIV, ST_WD_MUL, ST_WD_DIV, ST_WRITE, ST_EMIT
  } state_t;

  function automatic logic [23:0] sat24(input logic [NW-1:0] x);
    return (|x[NW-1:24]) ? 24'hFFFFFF : x[23:0];
  endfunction

  function automatic logic [23:0] clamp_add(input logic [23:0] base, input logic neg,
                                            input logic [NW-1:0] q);
    logic [26:0] s;
    if (|q[NW-1:25]) begin
      return neg ? 24'h0 : 24'hFFFFFF;
    end
    s = neg ? ({3'b0, base} - {2'b0, q[24:0]}) : ({3'b0, base} + {2'b0, q[24:0]});
    if (s[26]) begin
      return 24'h0;
    end
    if (|s[25:24]) begin
      return 24'hFFFFFF;
    end
    return s[23:0];
  endfunction

  chan_t            mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  chan_t            rd_q;
  logic             rd_vld_r;
  chan_t            ld;
  chan_t            w_r;
  tbt_pkg::cmd_t    cmd_r;
  tbt_pkg::res_t    res_r;
  tbt_pkg::md_req_t md_req_r;
  state_t           state_r;
  logic             dneg_r;
  logic [24:0]      dabs_r;
  logic             eneg_r;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             mem_we;

  logic [23:0]        s8;
  logic signed [34:0] thr_full;
  logic [24:0]        thr_sat;
  logic               touched;
  logic [24:0]        d;
  logic               dneg;
  logic [24:0]        dabs;
  logic [25:0]        e;
  logic               eneg;
  logic [24:0]        eabs;
  logic [24:0]        g;
  logic [24:0]        den;
  logic [15:0]        fpd;
  logic [15:0]        ad16;
  logic [24:0]        sum;
  logic [23:0]        sum_sat;
  logic [24:0]        bup;
  logic [24:0]        dup;
  logic [23:0]        b_st;
  logic [23:0]        dv_st;

  assign raddr   = AW'(cq_dout.ch);
  assign waddr   = AW'(cmd_r.ch);
  assign mem_we  = (state_r == ST_WRITE);
  assign cq_pop  = (state_r == ST_IDLE) && !cq_empty;
  assign rq_push = (state_r == ST_EMIT) && !rq_full;
  assign rq_din  = res_r;
  assign md_req  = md_req_r;
  assign ld      = rd_vld_r ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= w_r;
    end
    rd_q     <= mem[raddr];
    rd_vld_r <= vld_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // threshold from the state before the update; product arrives from the unit
  always_comb begin
    s8       = {cmd_r.smp, 8'b0};
    thr_full = $signed({11'b0, w_r.b}) - $signed({3'b0, md_res[39:8]})
             - $signed({11'b0, cfg.toff});
    if (thr_full < -35'sd16777216) begin
      thr_sat = 25'h1000000;
    end else if (thr_full > 35'sd16777215) begin
      thr_sat = 25'h0FFFFFF;
    end else begin
      thr_sat = thr_full[24:0];
    end
    touched = $signed({1'b0, s8}) < $signed(thr_sat);

    d    = {1'b0, s8} - {1'b0, w_r.b};
    dneg = d[24];
    dabs = dneg ? (25'd0 - d) : d;
    e    = {1'b0, dabs_r} - {2'b0, w_r.dv};
    eneg = e[25];
    eabs = eneg ? 25'(26'd0 - e) : e[24:0];
    g    = {1'b0, cfg.toff} + {6'b0, cfg.sp, 9'b0};
    den  = {1'b0, cfg.wp, 8'b0};
    fpd  = (cfg.fp == '0) ? 16'd1 : cfg.fp;

    ad16    = (cmd_r.smp > w_r.fs) ? (cmd_r.smp - w_r.fs) : (w_r.fs - cmd_r.smp);
    sum     = {1'b0, w_r.ads} + {9'b0, ad16};
    sum_sat = sum[24] ? 24'hFFFFFF : sum[23:0];

    bup   = {1'b0, w_r.b} + {1'b0, w_r.bs};
    dup   = {1'b0, w_r.dv} + {1'b0, w_r.ds};
    b_st  = (s8 > w_r.b) ? (bup[24] ? 24'hFFFFFF : bup[23:0])
                         : ((w_r.b >= w_r.bs) ? (w_r.b - w_r.bs) : 24'h0);
    dv_st = (dabs > {1'b0, w_r.dv}) ? (dup[24] ? 24'hFFFFFF : dup[23:0])
                                    : ((w_r.ds < w_r.dv) ? (w_r.dv - w_r.ds) : 24'h0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      md_req_r.start <= 1'b0;
    end else begin
      md_req_r.start <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!cq_empty) begin
            cmd_r <= cq_dout;
            if (cq_dout.op == tbt_pkg::OP_ERR) begin
              res_r   <= '{touched: 1'b0, thr: '1, base: '0, dev: '0, status: 1'b1};
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          w_r      <= ld;
          md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_MUL, a: {26'b0, ld.dv},
                        b: {9'b0, cfg.tf}};
          state_r  <= ST_THR;
        end
        ST_THR: begin
          if (md_done) begin
            res_r.touched <= touched;
            res_r.thr     <= thr_sat;
            res_r.status  <= 1'b0;
            dneg_r        <= dneg;
            dabs_r        <= dabs;
            case (cmd_r.op)
              tbt_pkg::OP_CAL: begin
                if (w_r.cc == '0) begin
                  w_r.fs  <= cmd_r.smp;
                  w_r.b   <= s8;
                  w_r.dv  <= '0;
                  w_r.ads <= '0;
                  w_r.cc  <= 8'd1;
                  state_r <= ST_WRITE;
                end else begin
                  w_r.ads <= sum_sat;
                  if (w_r.cc >= cfg.cs) begin
                    md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_DIV,
                                  a: {18'b0, sum_sat, 8'b0}, b: {17'b0, w_r.cc}};
                    state_r  <= ST_CAL_DIV;
                  end else begin
                    w_r.cc  <= w_r.cc + 8'd1;
                    state_r <= ST_WRITE;
                  end
                end
              end
              tbt_pkg::OP_STEADY: begin
                w_r.b   <= b_st;
                w_r.dv  <= dv_st;
                state_r <= ST_WRITE;
              end
              tbt_pkg::OP_WARM: begin
                md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_MUL, a: {25'b0, dabs}, b: g};
                state_r  <= ST_WB_MUL;
              end
              default: begin
                res_r.base <= w_r.b;
                res_r.dev  <= w_r.dv;
                state_r    <= ST_EMIT;
              end
            endcase
          end
        end
        ST_CAL_DIV: begin
          if (md_done) begin
            w_r.dv   <= sat24(md_res);
            md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_MUL, a: {26'b0, w_r.b},
                          b: {15'b0, cfg.sp}};
            state_r  <= ST_BS_MUL;
          end
        end
        ST_BS_MUL: begin
          if (md_done) begin
            md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_DIV, a: md_res, b: {9'b0, fpd}};
            state_r  <= ST_BS_DIV;
          end
        end
        ST_BS_DIV: begin
          if (md_done) begin
            w_r.bs   <= sat24(md_res);
            md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_MUL, a: {26'b0, w_r.dv},
                          b: {15'b0, cfg.sp}};
            state_r  <= ST_DS_MUL;
          end
        end
        ST_DS_MUL: begin
          if (md_done) begin
            md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_DIV, a: md_res, b: {9'b0, fpd}};
            state_r  <= ST_DS_DIV;
          end
        end
        ST_DS_DIV: begin
          if (md_done) begin
            w_r.ds  <= sat24(md_res);
            w_r.cc  <= '0;
            state_r <= ST_WRITE;
          end
        end
        ST_WB_MUL: begin
          if (md_done) begin
            md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_DIV, a: md_res, b: den};
            state_r  <= ST_WB_DIV;
          end
        end
        ST_WB_DIV: begin
          if (md_done) begin
            w_r.b    <= clamp_add(w_r.b, dneg_r, md_res);
            eneg_r   <= eneg;
            md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_MUL, a: {25'b0, eabs}, b: g};
            state_r  <= ST_WD_MUL;
          end
        end
        ST_WD_MUL: begin
          if (md_done) begin
            md_req_r <= '{start: 1'b1, op: tbt_pkg::MD_DIV, a: md_res, b: den};
            state_r  <= ST_WD_DIV;
          end
        end
        ST_WD_DIV: begin
          if (md_done) begin
            w_r.dv  <= clamp_add(w_r.dv, eneg_r, md_res);
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          res_r.base <= w_r.b;
          res_r.dev  <= w_r.dv;
          state_r    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!rq_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_err_res: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push && rq_din.status |-> rq_din.base == '0 && rq_din.dev == '0 && !rq_din.touched)
    else $error("error transaction carries channel data");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> !mem_we)
    else $error("channel state written twice for one transaction");

  a_start_gap: assert property (@(posedge clk) disable iff (!rst_n)
    md_req_r.start |=> !md_req_r.start)
    else $error("back-to-back requests to the arithmetic unit");

  a_pop_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |=> !cq_pop)
    else $error("command taken while previous one still in flight");

endmodule

[tb/touch_baseline_tracker_tb.sv]
module touch_baseline_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbt_pkg::*;

  // Modes the package leaves unnamed.
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;
  localparam int NCH       = 16;
  localparam int LIMIT     = 2_000_000;
  localparam int DRAIN_CYC = 300;        // a little over the slowest transaction

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  ch;
    logic [15:0] smp;
    logic [31:0] el;
  } touch_item_t;

  typedef struct {
    logic               touched;
    logic signed [24:0] thr;
    logic [23:0]        base;
    logic [23:0]        dev;
    logic               status;
  } touch_report_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 0, full;
  logic [1:0]  in_mode = '0;
  logic [3:0]  in_channel = '0;
  logic [15:0] in_sample = '0;
  logic [31:0] in_elapsed_ms = '0;
  logic        empty, pop = 0;
  logic        out_touched;
  logic signed [24:0] out_threshold;
  logic [23:0] out_baseline_out, out_deviation_out;
  logic        out_status;

  touch_baseline_tracker DUT (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .in_mode, .in_channel, .in_sample, .in_elapsed_ms,
    .empty, .pop, .out_touched, .out_threshold, .out_baseline_out,
    .out_deviation_out, .out_status
  );

  initial forever #5 clk = ~clk;

  // Register mirror, updated only while the block is idle.
  logic [4:0]  m_ciu  = CIU_RST;
  logic [9:0]  m_sp   = SP_RST;
  logic [15:0] m_wp   = WP_RST;
  logic [15:0] m_fp   = FP_RST;
  logic [15:0] m_tf   = TF_RST;
  logic [23:0] m_toff = TOFF_RST;
  logic [7:0]  m_cs   = CS_RST;

  // Per-channel tracker state as the block should hold it.
  logic [23:0] base_q [NCH];
  logic [23:0] dev_q [NCH];
  logic [23:0] bstep_q [NCH];
  logic [23:0] dstep_q [NCH];
  logic [7:0]  ccount_q [NCH];
  logic [15:0] first_q [NCH];
  logic [23:0] adsum_q [NCH];

  touch_item_t   pending [$];
  touch_report_t expect_q [$];
  int errors = 0;
  int cycles = 0;

  initial begin
    for (int c = 0; c < NCH; c++) begin
      base_q[c] = '0; dev_q[c] = '0; bstep_q[c] = '0; dstep_q[c] = '0;
      ccount_q[c] = '0; first_q[c] = '0; adsum_q[c] = '0;
    end
  end

  function automatic logic [23:0] sat24(longint v);
    if (v < 0) return '0;
    if (v > 64'hFFFFFF) return 24'hFFFFFF;
    return v[23:0];
  endfunction

  // Fixed tracking step: value * sample period / filter period.
  function automatic logic [23:0] slow_step(logic [23:0] v);
    longint fp0;
    fp0 = (m_fp == 0) ? 1 : longint'(m_fp);
    return sat24((longint'(v) * longint'(m_sp)) / fp0);
  endfunction

  // Predict one report and advance the channel state.
  function automatic touch_report_t track_channel(touch_item_t it);
    touch_report_t r;
    longint s8, thr, b, dv, d, ad, g, den, bs, ds, q;
    int unsigned k, adiff, sum;
    s8 = longint'(it.smp) * 256;
    if (it.ch >= m_ciu || it.ch >= NCH) begin
      r.touched = 0; r.thr = '1; r.base = '0; r.dev = '0; r.status = 1;
      return r;
    end
    thr = longint'(base_q[it.ch]) - (longint'(m_tf) * longint'(dev_q[it.ch])) / 256
          - longint'(m_toff);
    if (thr < -16777216) thr = -16777216;
    if (thr > 16777215) thr = 16777215;
    r.touched = (s8 < thr);
    r.thr = thr[24:0];
    if (it.mode == MODE_CAL) begin
      k = ccount_q[it.ch];
      if (k == 0) begin
        first_q[it.ch]  = it.smp;
        base_q[it.ch]   = {it.smp, 8'h00};
        dev_q[it.ch]    = '0;
        adsum_q[it.ch]  = '0;
        ccount_q[it.ch] = 1;
      end else begin
        adiff = (it.smp > first_q[it.ch]) ? it.smp - first_q[it.ch]
                                          : first_q[it.ch] - it.smp;
        sum = adsum_q[it.ch] + adiff;
        adsum_q[it.ch] = sat24(sum);
        if (k >= m_cs) begin
          q = (longint'(adsum_q[it.ch]) * 256) / k;
          dev_q[it.ch]    = sat24(q);
          bstep_q[it.ch]  = slow_step(base_q[it.ch]);
          dstep_q[it.ch]  = slow_step(dev_q[it.ch]);
          ccount_q[it.ch] = '0;
        end else begin
          ccount_q[it.ch] = 8'(k + 1);
        end
      end
    end else if (it.mode == MODE_TRACK) begin
      b  = base_q[it.ch];
      dv = dev_q[it.ch];
      d  = s8 - b;
      ad = (d < 0) ? -d : d;
      if (it.el < m_wp) begin
        // warm-up: proportional gain, truncated toward zero
        g   = longint'(m_toff) + 2 * longint'(m_sp) * 256;
        den = 256 * longint'(m_wp);
        base_q[it.ch] = sat24(b + (g * d) / den);
        dev_q[it.ch]  = sat24(dv + (g * (ad - dv)) / den);
      end else begin
        bs = bstep_q[it.ch];
        ds = dstep_q[it.ch];
        base_q[it.ch] = sat24((s8 > b) ? b + bs : b - bs);
        if (ad > dv) dev_q[it.ch] = sat24(dv + ds);
        else dev_q[it.ch] = sat24(dv - ((ds < dv) ? ds : dv));
      end
    end
    r.base = base_q[it.ch];
    r.dev = dev_q[it.ch];
    r.status = 0;
    return r;
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) expect_q.push_back(track_channel(pending.pop_front()));
      if (push && full) begin
        // offer stays up until taken
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 0;
      end else if (pending.size() > 0) begin
        in_mode       <= pending[0].mode;
        in_channel    <= pending[0].ch;
        in_sample     <= pending[0].smp;
        in_elapsed_ms <= pending[0].el;
        push          <= 1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        push <= 0;
      end
    end
  end

  // Monitor: checks each popped result; the pop duty cycle is redrawn at random during the run.
  int pop_pct = 100;
  always @(posedge clk) begin : mon
    touch_report_t want;
    if (rst_n && pop && !empty) begin
      if (expect_q.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        want = expect_q.pop_front();
        if (out_touched !== want.touched) begin
          $display("%0t: touched exp %0d got %0d", $time, want.touched, out_touched);
          errors++;
        end
        if (out_threshold !== want.thr) begin
          $display("%0t: threshold exp %0d got %0d", $time, want.thr, out_threshold);
          errors++;
        end
        if (out_baseline_out !== want.base) begin
          $display("%0t: baseline exp %h got %h", $time, want.base, out_baseline_out);
          errors++;
        end
        if (out_deviation_out !== want.dev) begin
          $display("%0t: deviation exp %h got %h", $time, want.dev, out_deviation_out);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, out_status);
          errors++;
        end
      end
    end
    if (cycles % 256 == 0) begin
      case ($urandom_range(0, 4))
        0, 1: pop_pct = 100;
        2: pop_pct = 60;
        3: pop_pct = 20;
        default: pop_pct = 5;
      endcase
    end
    pop <= ($urandom_range(1, 100) <= pop_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_CIU:  m_ciu  = val[4:0];
      REG_SP:   m_sp   = val[9:0];
      REG_WP:   m_wp   = val[15:0];
      REG_FP:   m_fp   = val[15:0];
      REG_TF:   m_tf   = val[15:0];
      REG_TOFF: m_toff = val[23:0];
      REG_CS:   m_cs   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int ciu, int sp, int wp, int fp, int tf, int toff, int cs);
    reg_write(REG_CIU, ciu);
    reg_write(REG_SP, sp);
    reg_write(REG_WP, wp);
    reg_write(REG_FP, fp);
    reg_write(REG_TF, tf);
    reg_write(REG_TOFF, toff);
    reg_write(REG_CS, cs);
  endtask

  task automatic add_item(logic [1:0] mode, logic [3:0] ch, int smp, logic [31:0] el);
    touch_item_t it;
    it.mode = mode; it.ch = ch;
    it.smp = (smp < 0) ? 16'd0 : (smp > 65535) ? 16'hFFFF : 16'(smp);
    it.el = el;
    pending.push_back(it);
  endtask

  // Let everything drain, then give the back end time to go quiet.
  task automatic wait_idle();
    while (pending.size() != 0 || expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Mostly full calibration runs followed by tracking on the same channel,
  // the rest random noise and cut-short calibrations.
  task automatic random_phase(int n);
    int added, ch, lvl, amp, len, ntrk;
    logic [31:0] el;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 7) begin
        if (m_ciu != 0 && $urandom_range(0, 4) != 0)
          ch = $urandom_range(0, ((m_ciu > NCH) ? NCH : m_ciu) - 1);
        else
          ch = $urandom_range(0, NCH - 1);
        lvl = $urandom_range(0, 65535);
        amp = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20000) : $urandom_range(0, 500);
        len = m_cs + 1;
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
        for (int i = 0; i < len; i++)
          add_item(MODE_CAL, ch, lvl + $urandom_range(0, 2 * amp) - amp, $urandom);
        ntrk = $urandom_range(1, 30);
        el = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(0, 2 * m_wp + 2);
        for (int i = 0; i < ntrk; i++) begin
          if ($urandom_range(0, 4) == 0)
            add_item(MODE_TRACK, ch, lvl - $urandom_range(0, 65535), el);  // touch dip
          else if ($urandom_range(0, 9) == 0)
            add_item(MODE_QUERY, ch, lvl, el);
          else
            add_item(MODE_TRACK, ch, lvl + $urandom_range(0, 2 * amp) - amp, el);
          el += m_sp;
        end
        added += len + ntrk;
      end else begin
        for (int i = 0; i < 8; i++)
          add_item($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 65535),
                   $urandom);
        added += 8;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: short calibration so a run closes within a few items.
    reg_write(REG_CS, 2);
    add_item(MODE_CAL, 0, 65535, 0);
    add_item(MODE_CAL, 0, 0, 0);
    add_item(MODE_CAL, 0, 65535, 0);               // run closes, steps derived
    add_item(MODE_TRACK, 0, 0, 0);                 // warm-up, large negative step
    add_item(MODE_TRACK, 0, 65535, 32'hFFFF_FFFF); // steady tracking up
    add_item(MODE_TRACK, 0, 0, 32'hFFFF_FFFF);     // steady tracking down
    add_item(MODE_QUERY, 0, 0, 0);                 // query only
    add_item(MODE_RSVD, 0, 65535, 0);              // reserved mode, no update
    add_item(MODE_CAL, 1, 1000, 5);
    add_item(MODE_CAL, 1, 1000, 5);
    add_item(MODE_CAL, 1, 1000, 5);                // zero deviation
    add_item(MODE_TRACK, 1, 1000, 1999);           // last warm-up ms
    add_item(MODE_TRACK, 1, 1000, 2000);           // first steady ms, equal sample
    add_item(MODE_TRACK, 1, 0, 2000);              // touched
    add_item(MODE_TRACK, 10, 500, 0);              // first channel not in use
    add_item(MODE_CAL, 15, 500, 0);
    add_item(MODE_CAL, 9, 0, 0);
    add_item(MODE_CAL, 9, 0, 0);
    add_item(MODE_CAL, 9, 0, 0);
    add_item(MODE_TRACK, 9, 65535, 100);
    add_item(MODE_TRACK, 9, 65535, 100);
    add_item(MODE_QUERY, 9, 65535, 100);
    wait_idle();

    write_all(10, 10, 2000, 10000, 768, 2560, 20);
    random_phase(230);
    write_all(16, 1, 1, 1, 0, 0, 1);
    random_phase(230);
    write_all(16, 1023, 65535, 65535, 65535, 16777215, 4);
    random_phase(230);
    write_all(1, 500, 0, 0, 256, 1000, 255);   // never warm-up, filter period zero
    random_phase(230);
    write_all(31, 1023, 300, 7, 100, 500, 3);
    random_phase(230);
    write_all(0, 10, 2000, 100, 768, 2560, 2); // no channel in use
    random_phase(50);
    write_all(16, 1023, 65535, 1, 65535, 16777215, 0);
    random_phase(200);
    for (int p = 0; p < 2; p++) begin
      write_all($urandom_range(1, 16), $urandom_range(1, 1023), $urandom_range(1, 65535),
                $urandom_range(1, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 16777215), $urandom_range(1, 12));
      random_phase(220);
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
